// ===== rtl/core/lpt_list_scheduler_min_heap_top_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Simulation builds get the checks; builds that define SYNTH get empty bodies.
`ifndef LPT_LIST_SCHEDULER_MIN_HEAP_TOP_DEFINES_SVH
`define LPT_LIST_SCHEDULER_MIN_HEAP_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`ifndef SYNTH
`define LPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpt: same-cycle check failed");
`else
`define LPT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`ifndef SYNTH
`define LPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpt: next-cycle check failed");
`else
`define LPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/lpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpt_pkg;

    // Heap capacity and field widths.
    localparam int MAX_MACHINES = 16;
    localparam int LEN_W        = 16;
    localparam int TIME_W       = 32;
    localparam int ID_W         = 5;
    localparam int CNT_W        = 5;

    // Heap positions are 1-based, so the position needs room for MAX_MACHINES itself.
    localparam int ADDR_W  = $clog2(MAX_MACHINES + 1);
    localparam int MEM_AW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CHILD_W = ADDR_W + 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(3);

    // One heap slot: free time and machine number.
    typedef struct packed {
        logic [TIME_W-1:0] key;
        logic [ID_W-1:0]   id;
    } heap_entry_t;

    // Write request into the heap store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        heap_entry_t       data;
    } heap_wr_t;

    // Machine count as used by the heap: zero counts as one, large values saturate.
    function automatic logic [ADDR_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt);
        logic [ADDR_W-1:0] res;
        if (cnt == '0)
        begin
            res = ADDR_W'(1);
        end
        else if (int'(cnt) > MAX_MACHINES)
        begin
            res = ADDR_W'(MAX_MACHINES);
        end
        else
        begin
            res = ADDR_W'(cnt);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpt_job_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Job channel: one beat carries one job length.
interface lpt_job_if;
    import lpt_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] job_length;

    modport source (output valid, output job_length, input ready);
    modport sink   (input valid, input job_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpt_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one beat carries one assignment.
interface lpt_res_if;
    import lpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   machine_id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic              time_overflow;

    modport source (output valid, output machine_id, output start_time,
                    output finish_time, output time_overflow, input ready);
    modport sink   (input valid, input machine_id, input start_time,
                    input finish_time, input time_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpt_heap_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Heap slot storage with one write port and one read port.
// A slot that has not been written since the last clear reads as its
// reload value: free time zero and machine number equal to its position.
module lpt_heap_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clear,
    input  wire lpt_pkg::heap_wr_t           wr,
    input  wire logic [lpt_pkg::ADDR_W-1:0]  rd_addr,
    output lpt_pkg::heap_entry_t             rd_data
);
    import lpt_pkg::*;

    heap_entry_t             mem_reg [MAX_MACHINES];
    logic [MAX_MACHINES-1:0] vld_reg;

    logic [ADDR_W-1:0] wr_off;
    logic [ADDR_W-1:0] rd_off;
    logic [MEM_AW-1:0] wr_idx;
    logic [MEM_AW-1:0] rd_idx;

    // Positions are 1-based; the array is 0-based.
    assign wr_off = wr.addr - ADDR_W'(1);
    assign rd_off = rd_addr - ADDR_W'(1);
    assign wr_idx = wr_off[MEM_AW-1:0];
    assign rd_idx = rd_off[MEM_AW-1:0];

    // Written flags: cleared by reset and by a reload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (clear)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // Slot contents.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr_idx] <= wr.data;
        end
    end

    // Read port, falling back to the reload value.
    always_comb
    begin
        if (vld_reg[rd_idx])
        begin
            rd_data = mem_reg[rd_idx];
        end
        else
        begin
            rd_data.key = '0;
            rd_data.id  = ID_W'(rd_addr);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpt_list_scheduler_min_heap_top.sv =====
// LPT list scheduler built on a binary min-heap of machines keyed by free time.
// Job channel (job): one beat per job carries job_length. Each job goes to the
// machine that becomes free first; ties resolve by heap order.
// Result channel (res): one beat per job with machine_id, start_time, finish_time
// (start plus length minus one, saturated; start for a zero length) and time_overflow,
// set when the machine's new free time saturates at the largest time.
// Configuration: a write of cfg_wr_data with cfg_wr_en reloads the heap with
// machines 1 to count, all free at time zero. Write it only while idle.
// Throughput: job.ready is high only between jobs, so a new job waits until the last
// is through. A shared key comparator and a heap store with one read and one write
// port walk the sift-down in a left-read, a right-read and a compare step per level
// and the sift-up in one step per level.
// Stall: the result sits in an output register; the next job is accepted while it
// waits, and that job holds before its result step until the register frees up.
// Reset: the heap holds machines 1 to 3 free at time zero, no result is pending,
// and the block is ready at once.
`timescale 1ns / 1ps
`default_nettype none
`include "lpt_list_scheduler_min_heap_top_defines.svh"

module lpt_list_scheduler_min_heap_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lpt_pkg::CNT_W-1:0]  cfg_wr_data,
    lpt_job_if.sink                         job,
    lpt_res_if.source                       res
);
    import lpt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ROOT,
        ST_RD_LAST,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_DN_PLACE,
        ST_CALC,
        ST_UP_STEP
    } state_t;

    state_t             state_reg,      state_next;
    logic [ADDR_W-1:0]  fill_reg,       fill_next;
    logic [LEN_W-1:0]   len_reg,        len_next;
    heap_entry_t        top_reg,        top_next;
    heap_entry_t        last_reg,       last_next;
    heap_entry_t        cand_reg,       cand_next;
    logic [ADDR_W-1:0]  parent_reg,     parent_next;
    logic [CHILD_W-1:0] child_reg,      child_next;
    logic               out_valid_reg,  out_valid_next;
    logic [ID_W-1:0]    out_id_reg,     out_id_next;
    logic [TIME_W-1:0]  out_start_reg,  out_start_next;
    logic [TIME_W-1:0]  out_finish_reg, out_finish_next;
    logic               out_ovf_reg,    out_ovf_next;

    heap_wr_t           heap_wr;
    logic [ADDR_W-1:0]  rd_addr;
    heap_entry_t        rd_data;

    logic [TIME_W-1:0]  cmp_a;
    logic [TIME_W-1:0]  cmp_b;
    logic               cmp_lt;

    logic [ADDR_W-1:0]  fill_dec;
    logic [CHILD_W-1:0] child_inc;
    logic [CHILD_W-1:0] child_dbl;
    logic [TIME_W:0]    sum_wide;
    logic [TIME_W:0]    fin_wide;

    lpt_heap_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_wr_en),
        .wr      (heap_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared key comparator; the sequencer picks its operands.
    always_comb
    begin
        cmp_a  = (state_reg == ST_DN_RIGHT) ? rd_data.key : last_reg.key;
        cmp_b  = (state_reg == ST_UP_STEP) ? rd_data.key : cand_reg.key;
        cmp_lt = cmp_a < cmp_b;
    end

    // Heap position arithmetic.
    assign fill_dec  = fill_reg - ADDR_W'(1);
    assign child_inc = child_reg + CHILD_W'(1);
    assign child_dbl = child_reg << 1;

    // Time arithmetic for the result step.
    assign sum_wide = (TIME_W + 1)'(top_reg.key) + (TIME_W + 1)'(len_reg);
    assign fin_wide = sum_wide - (TIME_W + 1)'(1);

    // Read address for the single heap port.
    always_comb
    begin
        unique case (state_reg)
            ST_RD_ROOT:  rd_addr = ADDR_W'(1);
            ST_RD_LAST:  rd_addr = fill_reg;
            ST_DN_LEFT:  rd_addr = child_reg[ADDR_W-1:0];
            ST_DN_RIGHT: rd_addr = child_inc[ADDR_W-1:0];
            ST_UP_STEP:  rd_addr = parent_reg >> 1;
            default:     rd_addr = ADDR_W'(1);
        endcase
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        top_next        = top_reg;
        last_next       = last_reg;
        cand_next       = cand_reg;
        parent_next     = parent_reg;
        child_next      = child_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_id_next     = out_id_reg;
        out_start_next  = out_start_reg;
        out_finish_next = out_finish_reg;
        out_ovf_next    = out_ovf_reg;
        heap_wr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    fill_next = clamp_count(cfg_wr_data);
                end
                if (job.valid)
                begin
                    len_next   = job.job_length;
                    state_next = ST_RD_ROOT;
                end
            end

            ST_RD_ROOT:
            begin
                top_next   = rd_data;
                state_next = ST_RD_LAST;
            end

            // The last slot leaves the heap and will fill the hole at the root.
            ST_RD_LAST:
            begin
                last_next   = rd_data;
                fill_next   = fill_dec;
                parent_next = ADDR_W'(1);
                child_next  = CHILD_W'(2);
                if (CHILD_W'(2) <= CHILD_W'(fill_dec))
                begin
                    state_next = ST_DN_LEFT;
                end
                else
                begin
                    state_next = ST_DN_PLACE;
                end
            end

            ST_DN_LEFT:
            begin
                cand_next = rd_data;
                if (child_inc <= CHILD_W'(fill_reg))
                begin
                    state_next = ST_DN_RIGHT;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end

            // Take the right child when its key is below the left one.
            ST_DN_RIGHT:
            begin
                if (cmp_lt)
                begin
                    cand_next  = rd_data;
                    child_next = child_inc;
                end
                state_next = ST_DN_CMP;
            end

            // Stop when the moving key is below the child; equal keys keep descending.
            ST_DN_CMP:
            begin
                if (cmp_lt)
                begin
                    state_next = ST_DN_PLACE;
                end
                else
                begin
                    heap_wr.en   = 1'b1;
                    heap_wr.addr = parent_reg;
                    heap_wr.data = cand_reg;
                    parent_next  = child_reg[ADDR_W-1:0];
                    child_next   = child_dbl;
                    if (child_dbl <= CHILD_W'(fill_reg))
                    begin
                        state_next = ST_DN_LEFT;
                    end
                    else
                    begin
                        state_next = ST_DN_PLACE;
                    end
                end
            end

            ST_DN_PLACE:
            begin
                heap_wr.en   = 1'b1;
                heap_wr.addr = parent_reg;
                heap_wr.data = last_reg;
                state_next   = ST_CALC;
            end

            // Load the result register and start the sift-up from the new last slot.
            ST_CALC:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = top_reg.id;
                    out_start_next = top_reg.key;
                    if (len_reg == '0)
                    begin
                        out_finish_next = top_reg.key;
                    end
                    else if (fin_wide[TIME_W])
                    begin
                        out_finish_next = '1;
                    end
                    else
                    begin
                        out_finish_next = fin_wide[TIME_W-1:0];
                    end
                    out_ovf_next = sum_wide[TIME_W];
                    last_next.id = top_reg.id;
                    if (sum_wide[TIME_W])
                    begin
                        last_next.key = '1;
                    end
                    else
                    begin
                        last_next.key = sum_wide[TIME_W-1:0];
                    end
                    fill_next   = fill_reg + ADDR_W'(1);
                    parent_next = fill_reg + ADDR_W'(1);
                    state_next  = ST_UP_STEP;
                end
            end

            // Rise while strictly below the parent; otherwise settle here.
            ST_UP_STEP:
            begin
                heap_wr.en = 1'b1;
                if ((parent_reg != ADDR_W'(1)) && cmp_lt)
                begin
                    heap_wr.addr = parent_reg;
                    heap_wr.data = rd_data;
                    parent_next  = parent_reg >> 1;
                end
                else
                begin
                    heap_wr.addr = parent_reg;
                    heap_wr.data = last_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, working registers and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= clamp_count(COUNT_RESET);
            len_reg        <= '0;
            top_reg        <= '0;
            last_reg       <= '0;
            cand_reg       <= '0;
            parent_reg     <= '0;
            child_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_start_reg  <= '0;
            out_finish_reg <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            len_reg        <= len_next;
            top_reg        <= top_next;
            last_reg       <= last_next;
            cand_reg       <= cand_next;
            parent_reg     <= parent_next;
            child_reg      <= child_next;
            out_valid_reg  <= out_valid_next;
            out_id_reg     <= out_id_next;
            out_start_reg  <= out_start_next;
            out_finish_reg <= out_finish_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    // Channel outputs.
    assign job.ready         = (state_reg == ST_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.machine_id    = out_id_reg;
    assign res.start_time    = out_start_reg;
    assign res.finish_time   = out_finish_reg;
    assign res.time_overflow = out_ovf_reg;

    // Between jobs the heap holds between one and MAX_MACHINES entries.
    `LPT_ASSERT_IMPL(a_fill_range, clk, rst_n, state_reg == ST_IDLE,
                     (fill_reg != '0) && (fill_reg <= ADDR_W'(MAX_MACHINES)))
    // A descent step always starts at the left child of the current parent.
    `LPT_ASSERT_IMPL(a_down_left, clk, rst_n, state_reg == ST_DN_LEFT,
                     child_reg == (CHILD_W'(parent_reg) << 1))
    // Heap writes stay inside the store.
    `LPT_ASSERT_IMPL(a_wr_range, clk, rst_n, heap_wr.en,
                     (heap_wr.addr != '0) && (heap_wr.addr <= ADDR_W'(MAX_MACHINES)))
    // A job beat starts the sequencer, which drops ready on the next cycle.
    `LPT_ASSERT_NEXT(a_busy_after_job, clk, rst_n, job.valid && job.ready, !job.ready)

endmodule

`default_nettype wire
